// ===== hdl/tcg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcg_pkg
// shared types, register codes and character constants of the glyph renderer
// ----------------------------------------------------------------------------
package tcg_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_XRES   = 3'd0,
        REG_YRES   = 3'd1,
        REG_CHARW  = 3'd2,
        REG_CHARH  = 3'd3,
        REG_FBBASE = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [12:0] x_res;
        logic [12:0] y_res;
        logic [3:0]  char_w;
        logic [4:0]  char_h;
        logic [31:0] fb_base;
    } cfg_t;

    localparam logic [12:0] XRES_RST   = 13'd640;
    localparam logic [12:0] YRES_RST   = 13'd480;
    localparam logic [3:0]  CHARW_RST  = 4'd8;
    localparam logic [4:0]  CHARH_RST  = 5'd16;
    localparam logic [31:0] FBBASE_RST = 32'd0;

    localparam logic [1:0] ACT_PRINT  = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_CURSOR = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [12:0] TAB_STEP = 13'd4;

    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // effective glyph width, clamped to 1..8
    function automatic logic [3:0] eff_width(input logic [3:0] cw);
        logic [3:0] w;
        if (cw == 4'd0)
        begin
            w = 4'd1;
        end
        else if (cw > 4'd8)
        begin
            w = 4'd8;
        end
        else
        begin
            w = cw;
        end
        return w;
    endfunction

    // top w bits of a glyph byte are kept
    function automatic logic [7:0] keep_mask(input logic [3:0] w);
        logic [7:0] m;
        m = ~(8'hFF >> w);
        return m;
    endfunction

endpackage

// ===== hdl/tcg_ram.sv =====
// ----------------------------------------------------------------------------
// tcg_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/tcg_div.sv =====
// ----------------------------------------------------------------------------
// tcg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tcg_div #(
    parameter int N = 13,
    parameter int D = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CW = $clog2(N + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  q_reg, q_next;
    logic [D-1:0]  rem_reg, rem_next;
    logic [D-1:0]  dvs_reg, dvs_next;
    logic [D+1:0]  diff;
    logic          ge;

    // trial subtract of the shifted remainder
    assign diff = {1'b0, rem_reg, q_reg[N-1]} - {2'b00, dvs_reg};
    assign ge   = ~diff[D+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(N);
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[D-1:0] : {rem_reg[D-2:0], q_reg[N-1]};
            q_next   = {q_reg[N-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            q_reg    <= q_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hdl/tcg_cfg.sv =====
// ----------------------------------------------------------------------------
// tcg_cfg
// apb register file for frame geometry, glyph size and frame base
// ----------------------------------------------------------------------------
module tcg_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcg_pkg::PADDR_W-1:0] paddr,
    input  logic [tcg_pkg::PDATA_W-1:0] pwdata,
    output logic [tcg_pkg::PDATA_W-1:0] prdata,
    output tcg_pkg::cfg_t               cfg,
    output logic                        cfg_wr
);

    tcg_pkg::cfg_t     cfg_reg, cfg_next;
    tcg_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx   = tcg_pkg::reg_idx_t'(paddr[tcg_pkg::PADDR_W-1:2]);
    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                tcg_pkg::REG_XRES:   cfg_next.x_res   = pwdata[12:0];
                tcg_pkg::REG_YRES:   cfg_next.y_res   = pwdata[12:0];
                tcg_pkg::REG_CHARW:  cfg_next.char_w  = pwdata[3:0];
                tcg_pkg::REG_CHARH:  cfg_next.char_h  = pwdata[4:0];
                tcg_pkg::REG_FBBASE: cfg_next.fb_base = pwdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tcg_pkg::REG_XRES:   prdata = 32'(cfg_reg.x_res);
            tcg_pkg::REG_YRES:   prdata = 32'(cfg_reg.y_res);
            tcg_pkg::REG_CHARW:  prdata = 32'(cfg_reg.char_w);
            tcg_pkg::REG_CHARH:  prdata = 32'(cfg_reg.char_h);
            tcg_pkg::REG_FBBASE: prdata = cfg_reg.fb_base;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_res   <= tcg_pkg::XRES_RST;
            cfg_reg.y_res   <= tcg_pkg::YRES_RST;
            cfg_reg.char_w  <= tcg_pkg::CHARW_RST;
            cfg_reg.char_h  <= tcg_pkg::CHARH_RST;
            cfg_reg.fb_base <= tcg_pkg::FBBASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg    = cfg_reg;
    // any write may change the character grid
    assign cfg_wr = wr_en;

endmodule

// ===== hdl/text_console_glyph_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit
// character console renderer: cursor tracking, glyph row writes, frame clear
// ----------------------------------------------------------------------------
//
//  port group   dir   handshake                  beat carries
//  ----------   ---   ------------------------   --------------------------------
//  apb          in    psel/penable/pwrite        one register write or read
//  in_*         in    in_valid / in_ready        one action (print, load, cursor)
//  out_*        out   out_valid / out_ready      one glyph row write or one clear
//
//  - glyph load, set cursor, nul and unused actions complete in their accept cycle
//  - a print is accepted, then planned in PLAN; a drawn glyph then passes
//    the address states RMUL, XMUL and BASE and writes one beat per glyph
//    row (clamped char_h rows) in DRAW, and a frame clear adds one beat in CLEAR;
//    the glyph ram read port gives one row per cycle unless the output stalls
//  - the first non-nul print after reset or after any register write first runs the
//    shared divider twice to get the grid size
//  - reset clears cursor and control state; glyph ram contents are kept
//  - out_ready low holds the row sequencer; the output register keeps one
//    finished beat so the next item is taken while the last beat waits
//
module text_console_glyph_renderer_unit #(
    parameter int GLYPH_COUNT    = 256,
    parameter int MAX_GLYPH_ROWS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  char_code,
    input  logic [31:0] fore_color,
    input  logic [31:0] back_color,
    input  logic [3:0]  glyph_row,
    input  logic [7:0]  glyph_bits,
    input  logic [11:0] set_col,
    input  logic [11:0] set_row,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [32:0] word_address,
    output logic [7:0]  row_bits,
    output logic [3:0]  pixel_count,
    output logic [31:0] fore_out,
    output logic [31:0] back_out,
    output logic        last
);

    localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_GLYPH_ROWS);
    localparam int GLW   = 8 + $clog2(MAX_GLYPH_ROWS) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_XGO,
        S_XWAIT,
        S_YGO,
        S_YWAIT,
        S_PLAN,
        S_RMUL,
        S_XMUL,
        S_BASE,
        S_DRAW,
        S_CLEAR
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    tcg_pkg::cfg_t cfg;
    logic          cfg_wr;

    tcg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    assign pready = 1'b1;

    // clamped glyph geometry
    logic [3:0] eff_w;
    logic [4:0] eff_h;
    logic [7:0] keep;

    assign eff_w = tcg_pkg::eff_width(cfg.char_w);
    assign keep  = tcg_pkg::keep_mask(eff_w);

    always_comb
    begin
        if (cfg.char_h == 5'd0)
        begin
            eff_h = 5'd1;
        end
        else if (cfg.char_h > 5'(MAX_GLYPH_ROWS))
        begin
            eff_h = 5'(MAX_GLYPH_ROWS);
        end
        else
        begin
            eff_h = cfg.char_h;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t        state_reg, state_next;
    logic          geom_ok_reg, geom_ok_next;
    logic [12:0]   cols_reg, cols_next;
    logic [12:0]   rows_reg, rows_next;
    logic [11:0]   cur_col_reg, cur_col_next;
    logic [11:0]   cur_row_reg, cur_row_next;
    logic [7:0]    ch_reg, ch_next;
    logic [31:0]   fore_reg, fore_next;
    logic [31:0]   back_reg, back_next;
    logic [11:0]   dcol_reg, dcol_next;
    logic [11:0]   drow_reg, drow_next;
    logic          clear_reg, clear_next;
    logic [AW-1:0] gbase_reg, gbase_next;
    logic          code_ok_reg, code_ok_next;
    logic [16:0]   t1_reg, t1_next;
    logic [15:0]   colcw_reg, colcw_next;
    logic [29:0]   t2_reg, t2_next;
    logic [32:0]   addr_reg, addr_next;
    logic [RW-1:0] r_reg, r_next;
    logic          out_valid_reg, out_valid_next;
    logic          kind_reg, kind_next;
    logic [32:0]   word_address_reg, word_address_next;
    logic [7:0]    row_bits_reg, row_bits_next;
    logic [3:0]    pixel_count_reg, pixel_count_next;
    logic [31:0]   fore_out_reg, fore_out_next;
    logic [31:0]   back_out_reg, back_out_next;
    logic          last_reg, last_next;

    // ------------------------------------------------------------------
    // shared divider: columns = x_res / width, rows = y_res / height
    // ------------------------------------------------------------------
    logic        div_start;
    logic [12:0] div_dividend;
    logic [4:0]  div_divisor;
    logic        div_done;
    logic [12:0] div_q;
    logic [12:0] div_q_fix;

    assign div_start    = (state_reg == S_XGO) || (state_reg == S_YGO);
    assign div_dividend = (state_reg == S_XGO) ? cfg.x_res : cfg.y_res;
    assign div_divisor  = (state_reg == S_XGO) ? {1'b0, eff_w} : eff_h;
    // an empty grid dimension counts as one cell
    assign div_q_fix    = (div_q == 13'd0) ? 13'd1 : div_q;

    tcg_div #(
        .N (13),
        .D (5)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // glyph ram: written by glyph loads, read unless stalled, one row per cycle
    // ------------------------------------------------------------------
    logic           in_fire;
    logic           ram_we;
    logic [GLW-1:0] wr_full;
    logic [AW-1:0]  rd_addr;
    logic [RW-1:0]  rd_row;
    logic [7:0]     rd_data;
    logic           slot_free;
    logic           row_last;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid & in_ready;
    assign wr_full  = GLW'(char_code) * GLW'(MAX_GLYPH_ROWS) + GLW'(glyph_row);
    // loads to a glyph code or row outside the store are dropped
    assign ram_we   = in_fire && (action == tcg_pkg::ACT_LOAD)
                      && ({1'b0, char_code} < 9'(GLYPH_COUNT))
                      && ({1'b0, glyph_row} < 5'(MAX_GLYPH_ROWS));

    assign slot_free = ~out_valid_reg | out_ready;
    assign row_last  = (5'(r_reg) == (eff_h - 5'd1));
    // read ahead when the current row leaves this cycle
    assign rd_row    = ((state_reg == S_DRAW) && slot_free && !row_last)
                       ? r_reg + RW'(1) : r_reg;
    assign rd_addr   = gbase_reg + AW'(rd_row);

    tcg_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_full[AW-1:0]),
        .wr_data (glyph_bits),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // cursor planning for a printed character
    // ------------------------------------------------------------------
    logic [12:0]    col13, row13;
    logic [11:0]    bs_col, bs_row;
    logic [12:0]    pcol, prow;
    logic [12:0]    wcol, wrow;
    logic           p_draw;
    logic [11:0]    p_dcol, p_drow;
    logic [7:0]     p_code;
    logic           p_clear;
    logic [GLW-1:0] p_gbase;

    assign col13 = {1'b0, cur_col_reg};
    assign row13 = {1'b0, cur_row_reg};
    // backspace from column zero goes to the end of the previous row,
    // and from the top row to the bottom row
    assign bs_col = (cur_col_reg == 12'd0) ? (cols_reg[11:0] - 12'd1)
                                           : (cur_col_reg - 12'd1);
    assign bs_row = (cur_col_reg != 12'd0) ? cur_row_reg
                  : (cur_row_reg == 12'd0) ? (rows_reg[11:0] - 12'd1)
                  : (cur_row_reg - 12'd1);

    always_comb
    begin
        pcol   = col13;
        prow   = row13;
        p_draw = 1'b0;
        p_dcol = cur_col_reg;
        p_drow = cur_row_reg;
        p_code = ch_reg;
        unique case (ch_reg)
            tcg_pkg::CH_CR:
            begin
                pcol = 13'd0;
            end
            tcg_pkg::CH_LF:
            begin
                pcol = 13'd0;
                prow = row13 + 13'd1;
            end
            tcg_pkg::CH_BS:
            begin
                pcol   = {1'b0, bs_col};
                prow   = {1'b0, bs_row};
                p_draw = 1'b1;
                p_dcol = bs_col;
                p_drow = bs_row;
                p_code = tcg_pkg::CH_SPACE;
            end
            tcg_pkg::CH_TAB:
            begin
                pcol = col13 + tcg_pkg::TAB_STEP;
            end
            default:
            begin
                pcol   = col13 + 13'd1;
                p_draw = 1'b1;
            end
        endcase
        // column overflow first, then row overflow
        if (pcol >= cols_reg)
        begin
            wcol = 13'd0;
            wrow = prow + 13'd1;
        end
        else
        begin
            wcol = pcol;
            wrow = prow;
        end
        p_clear = (wrow >= rows_reg);
    end

    assign p_gbase = GLW'(p_code) * GLW'(MAX_GLYPH_ROWS);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        geom_ok_next      = geom_ok_reg;
        cols_next         = cols_reg;
        rows_next         = rows_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        ch_next           = ch_reg;
        fore_next         = fore_reg;
        back_next         = back_reg;
        dcol_next         = dcol_reg;
        drow_next         = drow_reg;
        clear_next        = clear_reg;
        gbase_next        = gbase_reg;
        code_ok_next      = code_ok_reg;
        t1_next           = t1_reg;
        colcw_next        = colcw_reg;
        t2_next           = t2_reg;
        addr_next         = addr_reg;
        r_next            = r_reg;
        out_valid_next    = out_valid_reg & ~out_ready;
        kind_next         = kind_reg;
        word_address_next = word_address_reg;
        row_bits_next     = row_bits_reg;
        pixel_count_next  = pixel_count_reg;
        fore_out_next     = fore_out_reg;
        back_out_next     = back_out_reg;
        last_next         = last_reg;

        // grid size is stale after any register write
        if (cfg_wr)
        begin
            geom_ok_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (action == tcg_pkg::ACT_CURSOR)
                    begin
                        cur_col_next = set_col;
                        cur_row_next = set_row;
                    end
                    else if ((action == tcg_pkg::ACT_PRINT)
                             && (char_code != tcg_pkg::CH_NUL))
                    begin
                        ch_next    = char_code;
                        fore_next  = fore_color;
                        back_next  = back_color;
                        state_next = geom_ok_reg ? S_PLAN : S_XGO;
                    end
                end
            end
            S_XGO:
            begin
                state_next = S_XWAIT;
            end
            S_XWAIT:
            begin
                if (div_done)
                begin
                    cols_next  = div_q_fix;
                    state_next = S_YGO;
                end
            end
            S_YGO:
            begin
                state_next = S_YWAIT;
            end
            S_YWAIT:
            begin
                if (div_done)
                begin
                    rows_next    = div_q_fix;
                    geom_ok_next = 1'b1;
                    state_next   = S_PLAN;
                end
            end
            S_PLAN:
            begin
                dcol_next    = p_dcol;
                drow_next    = p_drow;
                clear_next   = p_clear;
                gbase_next   = p_gbase[AW-1:0];
                code_ok_next = ({1'b0, p_code} < 9'(GLYPH_COUNT));
                r_next       = '0;
                if (p_clear)
                begin
                    cur_col_next = 12'd0;
                    cur_row_next = 12'd0;
                end
                else
                begin
                    cur_col_next = wcol[11:0];
                    cur_row_next = wrow[11:0];
                end
                if (p_draw)
                begin
                    state_next = S_RMUL;
                end
                else if (p_clear)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RMUL:
            begin
                t1_next    = 17'(drow_reg) * 17'(eff_h);
                colcw_next = 16'(dcol_reg) * 16'(eff_w);
                state_next = S_XMUL;
            end
            S_XMUL:
            begin
                t2_next    = 30'(cfg.x_res) * 30'(t1_reg);
                state_next = S_BASE;
            end
            S_BASE:
            begin
                // row zero is read from the glyph ram in this cycle
                addr_next  = 33'(cfg.fb_base) + 33'(t2_reg) + 33'(colcw_reg);
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    kind_next         = tcg_pkg::KIND_GLYPH;
                    word_address_next = addr_reg;
                    row_bits_next     = code_ok_reg ? (rd_data & keep) : 8'd0;
                    pixel_count_next  = eff_w;
                    fore_out_next     = fore_reg;
                    back_out_next     = back_reg;
                    last_next         = row_last & ~clear_reg;
                    // next pixel row is one frame pitch further on
                    addr_next         = addr_reg + 33'(cfg.x_res);
                    if (row_last)
                    begin
                        state_next = clear_reg ? S_CLEAR : S_IDLE;
                    end
                    else
                    begin
                        r_next = r_reg + RW'(1);
                    end
                end
            end
            S_CLEAR:
            begin
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    kind_next         = tcg_pkg::KIND_CLEAR;
                    word_address_next = {1'b0, cfg.fb_base};
                    row_bits_next     = 8'd0;
                    pixel_count_next  = 4'd0;
                    fore_out_next     = 32'd0;
                    back_out_next     = 32'd0;
                    last_next         = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            geom_ok_reg      <= 1'b0;
            cols_reg         <= 13'd1;
            rows_reg         <= 13'd1;
            cur_col_reg      <= 12'd0;
            cur_row_reg      <= 12'd0;
            ch_reg           <= '0;
            fore_reg         <= '0;
            back_reg         <= '0;
            dcol_reg         <= '0;
            drow_reg         <= '0;
            clear_reg        <= 1'b0;
            gbase_reg        <= '0;
            code_ok_reg      <= 1'b0;
            t1_reg           <= '0;
            colcw_reg        <= '0;
            t2_reg           <= '0;
            addr_reg         <= '0;
            r_reg            <= '0;
            out_valid_reg    <= 1'b0;
            kind_reg         <= 1'b0;
            word_address_reg <= '0;
            row_bits_reg     <= '0;
            pixel_count_reg  <= '0;
            fore_out_reg     <= '0;
            back_out_reg     <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            geom_ok_reg      <= geom_ok_next;
            cols_reg         <= cols_next;
            rows_reg         <= rows_next;
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            ch_reg           <= ch_next;
            fore_reg         <= fore_next;
            back_reg         <= back_next;
            dcol_reg         <= dcol_next;
            drow_reg         <= drow_next;
            clear_reg        <= clear_next;
            gbase_reg        <= gbase_next;
            code_ok_reg      <= code_ok_next;
            t1_reg           <= t1_next;
            colcw_reg        <= colcw_next;
            t2_reg           <= t2_next;
            addr_reg         <= addr_next;
            r_reg            <= r_next;
            out_valid_reg    <= out_valid_next;
            kind_reg         <= kind_next;
            word_address_reg <= word_address_next;
            row_bits_reg     <= row_bits_next;
            pixel_count_reg  <= pixel_count_next;
            fore_out_reg     <= fore_out_next;
            back_out_reg     <= back_out_next;
            last_reg         <= last_next;
        end
    end

    // ------------------------------------------------------------------
    // result port
    // ------------------------------------------------------------------
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign word_address = word_address_reg;
    assign row_bits     = row_bits_reg;
    assign pixel_count  = pixel_count_reg;
    assign fore_out     = fore_out_reg;
    assign back_out     = back_out_reg;
    assign last         = last_reg;

endmodule

// ===== hdl/tcg_checker.sv =====
// ----------------------------------------------------------------------------
// tcg_checker
// port level checks of the glyph renderer result stream
// ----------------------------------------------------------------------------
module tcg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic [32:0] word_address,
    input logic [7:0]  row_bits,
    input logic [3:0]  pixel_count,
    input logic [31:0] fore_out,
    input logic [31:0] back_out,
    input logic        last
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_address)
                                    && $stable(row_bits) && $stable(last))
        else $error("stalled result beat changed");

    // a clear always ends the item
    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> last)
        else $error("clear beat without last");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> row_bits == 8'd0 && pixel_count == 4'd0
                              && fore_out == 32'd0 && back_out == 32'd0)
        else $error("clear beat carries pixel data");

    // glyph row: 1..8 pixels, nothing beyond the pixel count
    a_row_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> pixel_count >= 4'd1 && pixel_count <= 4'd8
                               && (row_bits & (8'hFF >> pixel_count)) == 8'd0)
        else $error("glyph row bits outside pixel count");

    // no new item while the current one still has beats to come
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken in the middle of an item");

endmodule

bind text_console_glyph_renderer_unit tcg_checker u_tcg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .word_address (word_address),
    .row_bits     (row_bits),
    .pixel_count  (pixel_count),
    .fore_out     (fore_out),
    .back_out     (back_out),
    .last         (last)
);

// ===== sim/text_console_glyph_renderer_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit_test
// self-checking bench for the text console glyph renderer
//
// A queue of console actions (prints, glyph loads, cursor moves) feeds a
// clocked driver. Each accepted action runs through a behavioral model of the
// console, and that model queues the glyph row writes and frame clears that
// the action should cause. A clocked monitor compares every result beat with
// the oldest queued write. The run steps through several frame geometries,
// including the extremes and out-of-range values, with random idling on both
// sides in all but the last two.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_unit_test;

    localparam real CLK_PERIOD    = 10.0;
    localparam int  SETTLE_CYCLES = 64;      // divider rerun plus one full glyph
    localparam int  ITEMS_PER_SEG = 10;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // one console action as driven on the input ports
    typedef struct packed {
        logic [1:0]  act;
        logic [7:0]  code;
        logic [31:0] fore;
        logic [31:0] back;
        logic [3:0]  grow;
        logic [7:0]  gbits;
        logic [11:0] scol;
        logic [11:0] srow;
    } console_item_t;

    // one frame buffer write as seen on the result ports
    typedef struct packed {
        logic        kind;
        logic [32:0] addr;
        logic [7:0]  bits;
        logic [3:0]  cnt;
        logic [31:0] fore;
        logic [31:0] back;
        logic        last;
    } frame_write_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // action channel
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  action     = '0;
    logic [7:0]  char_code  = '0;
    logic [31:0] fore_color = '0;
    logic [31:0] back_color = '0;
    logic [3:0]  glyph_row  = '0;
    logic [7:0]  glyph_bits = '0;
    logic [11:0] set_col    = '0;
    logic [11:0] set_row    = '0;

    // result channel
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [32:0] word_address;
    logic [7:0]  row_bits;
    logic [3:0]  pixel_count;
    logic [31:0] fore_out;
    logic [31:0] back_out;
    logic        last;

    // stimulus and scoreboard storage
    console_item_t console_items[$];
    frame_write_t  frame_writes_due[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_idle_pct  = 0;

    // console model state: register copy, cursor, glyph memory
    logic [12:0] cfg_xres  = tcg_pkg::XRES_RST;
    logic [12:0] cfg_yres  = tcg_pkg::YRES_RST;
    logic [3:0]  cfg_charw = tcg_pkg::CHARW_RST;
    logic [4:0]  cfg_charh = tcg_pkg::CHARH_RST;
    logic [31:0] cfg_base  = tcg_pkg::FBBASE_RST;
    logic [11:0] cur_col   = '0;
    logic [11:0] cur_row   = '0;
    logic [7:0]  glyph_mem [0:4095];

    // generator bookkeeping: which glyphs are fully loaded, current grid size
    bit          glyph_ready [0:255];
    logic [7:0]  ready_codes[$];
    int unsigned gen_cols;
    int unsigned gen_rows;

    text_console_glyph_renderer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .char_code    (char_code),
        .fore_color   (fore_color),
        .back_color   (back_color),
        .glyph_row    (glyph_row),
        .glyph_bits   (glyph_bits),
        .set_col      (set_col),
        .set_row      (set_row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .word_address (word_address),
        .row_bits     (row_bits),
        .pixel_count  (pixel_count),
        .fore_out     (fore_out),
        .back_out     (back_out),
        .last         (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // console model
    // ------------------------------------------------------------------------

    // clamped glyph geometry, shared by the model and the generator
    function automatic int unsigned clamp_w(logic [3:0] cw);
        return (cw == 0) ? 1 : ((cw > 8) ? 8 : cw);
    endfunction

    function automatic int unsigned clamp_h(logic [4:0] ch);
        return (ch == 0) ? 1 : ((ch > 16) ? 16 : ch);
    endfunction

    // queue one write per glyph row of a cell, returns the number queued
    function automatic int unsigned draw_cell(logic [7:0] code, int unsigned col,
                                              int unsigned row, int unsigned w,
                                              int unsigned h, logic [31:0] fore,
                                              logic [31:0] back);
        frame_write_t fw;
        logic [63:0]  addr;
        logic [7:0]   keep;
        keep = 8'(8'hFF << (8 - w));
        for (int unsigned r = 0; r < h; r++)
        begin
            addr = 64'(cfg_base) + 64'(cfg_xres) * (64'(row) * 64'(h) + 64'(r))
                 + 64'(col) * 64'(w);
            fw.kind = tcg_pkg::KIND_GLYPH;
            fw.addr = addr[32:0];
            fw.bits = glyph_mem[{code, r[3:0]}] & keep;
            fw.cnt  = w[3:0];
            fw.fore = fore;
            fw.back = back;
            fw.last = 1'b0;
            frame_writes_due.push_back(fw);
        end
        return h;
    endfunction

    // apply one accepted action to the model and queue what it writes
    function automatic void render_item(console_item_t it);
        int unsigned  w, h, cols, rows, col, row, n;
        frame_write_t fw;
        w = clamp_w(cfg_charw);
        h = clamp_h(cfg_charh);
        n = 0;
        if (it.act == tcg_pkg::ACT_LOAD)
        begin
            glyph_mem[{it.code, it.grow}] = it.gbits;
            return;
        end
        if (it.act == tcg_pkg::ACT_CURSOR)
        begin
            cur_col = it.scol;
            cur_row = it.srow;
            return;
        end
        // unused action and nul print leave everything alone
        if (it.act != tcg_pkg::ACT_PRINT || it.code == tcg_pkg::CH_NUL)
        begin
            return;
        end
        cols = 32'(cfg_xres) / w;
        rows = 32'(cfg_yres) / h;
        if (cols == 0) cols = 1;
        if (rows == 0) rows = 1;
        col = 32'(cur_col);
        row = 32'(cur_row);
        case (it.code)
            tcg_pkg::CH_CR:
            begin
                col = 0;
            end
            tcg_pkg::CH_LF:
            begin
                col = 0;
                row = row + 1;
            end
            tcg_pkg::CH_BS:
            begin
                // step back one cell, wrapping to the previous row and from
                // the top row to the bottom one, then blank that cell
                if (col == 0)
                begin
                    col = (cols - 1) & 32'hFFF;
                    row = (row == 0) ? ((rows - 1) & 32'hFFF) : row - 1;
                end
                else
                begin
                    col = col - 1;
                end
                n = draw_cell(tcg_pkg::CH_SPACE, col, row, w, h, it.fore, it.back);
            end
            tcg_pkg::CH_TAB:
            begin
                col = col + 4;
            end
            default:
            begin
                n = draw_cell(it.code, col, row, w, h, it.fore, it.back);
                col = col + 1;
            end
        endcase
        // column overflow first, then row overflow clears and homes
        if (col >= cols)
        begin
            col = 0;
            row = row + 1;
        end
        if (row >= rows)
        begin
            fw      = '0;
            fw.kind = tcg_pkg::KIND_CLEAR;
            fw.addr = {1'b0, cfg_base};
            frame_writes_due.push_back(fw);
            n   = n + 1;
            col = 0;
            row = 0;
        end
        cur_col = col[11:0];
        cur_row = row[11:0];
        if (n > 0)
        begin
            frame_writes_due[frame_writes_due.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver: one action beat at a time from the pending queue
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        console_item_t nxt;
        if (rst_n)
        begin
            // accepted beat: the fields still hold it, so feed the model
            if (in_valid && in_ready)
            begin
                render_item('{action, char_code, fore_color, back_color,
                              glyph_row, glyph_bits, set_col, set_row});
            end
            // valid holds until accepted; after that the next beat follows or the driver idles at random
            if (!in_valid || in_ready)
            begin
                if (console_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = console_items.pop_front();
                    action     <= nxt.act;
                    char_code  <= nxt.code;
                    fore_color <= nxt.fore;
                    back_color <= nxt.back;
                    glyph_row  <= nxt.grow;
                    glyph_bits <= nxt.gbits;
                    set_col    <= nxt.scol;
                    set_row    <= nxt.srow;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare every result beat with the oldest queued write
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [32:0] want, logic [32:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        frame_write_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frame_writes_due.size() == 0)
                begin
                    $error("result beat with nothing expected, word_address 0x%0h",
                           word_address);
                    mismatch_count++;
                end
                else
                begin
                    want = frame_writes_due.pop_front();
                    check_field("kind", 33'(want.kind), 33'(kind));
                    check_field("word_address", want.addr, word_address);
                    check_field("row_bits", 33'(want.bits), 33'(row_bits));
                    check_field("pixel_count", 33'(want.cnt), 33'(pixel_count));
                    check_field("fore_out", 33'(want.fore), 33'(fore_out));
                    check_field("back_out", 33'(want.back), 33'(back_out));
                    check_field("last", 33'(want.last), 33'(last));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------------

    // every field but the action random, so unused fields toggle too
    function automatic console_item_t blank_item();
        console_item_t it;
        it.act   = tcg_pkg::ACT_PRINT;
        it.code  = 8'($urandom);
        it.fore  = $urandom;
        it.back  = $urandom;
        it.grow  = 4'($urandom);
        it.gbits = 8'($urandom);
        it.scol  = 12'($urandom);
        it.srow  = 12'($urandom);
        return it;
    endfunction

    function automatic void push_load(logic [7:0] code, logic [3:0] row, logic [7:0] bits);
        console_item_t it;
        it       = blank_item();
        it.act   = tcg_pkg::ACT_LOAD;
        it.code  = code;
        it.grow  = row;
        it.gbits = bits;
        console_items.push_back(it);
    endfunction

    function automatic void push_cursor(logic [11:0] col, logic [11:0] row);
        console_item_t it;
        it      = blank_item();
        it.act  = tcg_pkg::ACT_CURSOR;
        it.scol = col;
        it.srow = row;
        console_items.push_back(it);
    endfunction

    function automatic void push_other(logic [1:0] act, logic [7:0] code);
        console_item_t it;
        it      = blank_item();
        it.act  = act;
        it.code = code;
        console_items.push_back(it);
    endfunction

    // a drawn glyph must be fully loaded before the print goes out
    function automatic void push_print(logic [7:0] code, logic [31:0] fore,
                                       logic [31:0] back);
        console_item_t it;
        logic [7:0]    g;
        g = (code == tcg_pkg::CH_BS) ? tcg_pkg::CH_SPACE : code;
        if (code != tcg_pkg::CH_NUL && code != tcg_pkg::CH_CR && code != tcg_pkg::CH_LF
            && code != tcg_pkg::CH_TAB && !glyph_ready[g])
        begin
            for (int r = 0; r < 16; r++)
            begin
                push_load(g, 4'(r), 8'($urandom));
            end
            glyph_ready[g] = 1'b1;
            ready_codes.push_back(g);
        end
        it      = blank_item();
        it.act  = tcg_pkg::ACT_PRINT;
        it.code = code;
        it.fore = fore;
        it.back = back;
        console_items.push_back(it);
    endfunction

    function automatic void set_geometry(logic [12:0] x, logic [12:0] y,
                                         logic [3:0] cw, logic [4:0] ch);
        gen_cols = x / clamp_w(cw);
        gen_rows = y / clamp_h(ch);
        if (gen_cols == 0) gen_cols = 1;
        if (gen_rows == 0) gen_rows = 1;
    endfunction

    // a fresh glyph costs sixteen loads, so new codes come rarely
    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)  return tcg_pkg::CH_CR;
        if (sel < 10) return tcg_pkg::CH_LF;
        if (sel < 15) return tcg_pkg::CH_BS;
        if (sel < 20) return tcg_pkg::CH_TAB;
        if (sel < 25 || ready_codes.size() == 0) return 8'($urandom_range(255, 1));
        return ready_codes[$urandom_range(ready_codes.size() - 1)];
    endfunction

    // mostly prints of loaded glyphs, with cursor jumps near the grid end so
    // wraps and clears come often; every queued beat counts, glyph loads too
    function automatic void random_items(int count);
        int base;
        int sel;
        int unsigned c;
        base = console_items.size();
        while (console_items.size() - base < count)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                push_print(pick_char(), $urandom, $urandom);
            end
            else if (sel < 72)
            begin
                push_load(8'($urandom), 4'($urandom), 8'($urandom));
            end
            else if (sel < 88)
            begin
                c = $urandom_range(99);
                if (c < 50)
                begin
                    push_cursor(12'(gen_cols - 1 - ((gen_cols > 3) ? $urandom_range(2) : 0)),
                                12'(gen_rows - 1));
                end
                else if (c < 80)
                begin
                    push_cursor(12'($urandom_range(gen_cols - 1)),
                                12'($urandom_range(gen_rows - 1)));
                end
                else
                begin
                    push_cursor(12'($urandom), 12'($urandom));
                end
            end
            else if (sel < 94)
            begin
                push_other(tcg_pkg::ACT_PRINT, tcg_pkg::CH_NUL);
            end
            else
            begin
                push_other(ACT_UNUSED, 8'($urandom));
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // register writes, only while the block is idle
    // ------------------------------------------------------------------------
    task automatic cfg_write(tcg_pkg::reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the write lands at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tcg_pkg::REG_XRES:   cfg_xres  = value[12:0];
            tcg_pkg::REG_YRES:   cfg_yres  = value[12:0];
            tcg_pkg::REG_CHARW:  cfg_charw = value[3:0];
            tcg_pkg::REG_CHARH:  cfg_charh = value[4:0];
            tcg_pkg::REG_FBBASE: cfg_base  = value;
            default:             ;
        endcase
    endtask

    task automatic program_frame(logic [12:0] x, logic [12:0] y, logic [3:0] cw,
                                 logic [4:0] ch, logic [31:0] base);
        cfg_write(tcg_pkg::REG_XRES, 32'(x));
        cfg_write(tcg_pkg::REG_YRES, 32'(y));
        cfg_write(tcg_pkg::REG_CHARW, 32'(cw));
        cfg_write(tcg_pkg::REG_CHARH, 32'(ch));
        cfg_write(tcg_pkg::REG_FBBASE, base);
        set_geometry(x, y, cw, ch);
    endtask

    // all beats sent, all writes seen, then let a print with no result settle
    task automatic drain();
        while (console_items.size() != 0 || in_valid || frame_writes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // phase one: sender idles lightly, receiver heavily
        send_idle_pct = 34;
        recv_idle_pct = 75;

        // directed part on the reset geometry: 80 by 30 cells
        set_geometry(tcg_pkg::XRES_RST, tcg_pkg::YRES_RST, tcg_pkg::CHARW_RST,
                     tcg_pkg::CHARH_RST);
        push_print(8'h41, 32'h0000_0000, 32'hFFFF_FFFF);
        push_load(8'hFF, 4'd0, 8'hFF);
        push_load(8'hFF, 4'd15, 8'h00);
        push_print(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
        push_print(tcg_pkg::CH_CR, $urandom, $urandom);
        push_print(tcg_pkg::CH_TAB, $urandom, $urandom);
        push_print(tcg_pkg::CH_LF, $urandom, $urandom);
        // backspace from column zero goes up a row
        push_print(tcg_pkg::CH_BS, $urandom, $urandom);
        // backspace from home wraps to the bottom right cell
        push_cursor(12'd0, 12'd0);
        push_print(tcg_pkg::CH_BS, $urandom, $urandom);
        // draw in the last cell: wrap, then clear
        push_print(8'h41, $urandom, $urandom);
        // tab past the right edge
        push_cursor(12'd78, 12'd5);
        push_print(tcg_pkg::CH_TAB, $urandom, $urandom);
        // newline on the bottom row clears
        push_cursor(12'd3, 12'd29);
        push_print(tcg_pkg::CH_LF, $urandom, $urandom);
        // ignored actions
        push_other(tcg_pkg::ACT_PRINT, tcg_pkg::CH_NUL);
        push_other(ACT_UNUSED, 8'hFF);
        // cursor far outside the grid
        push_cursor(12'hFFF, 12'hFFF);
        push_print(8'h41, $urandom, $urandom);
        push_cursor(12'hFFF, 12'd0);
        push_print(tcg_pkg::CH_BS, $urandom, $urandom);
        push_cursor(12'd0, 12'hFFF);
        push_print(tcg_pkg::CH_CR, $urandom, $urandom);
        random_items(ITEMS_PER_SEG / 2);

        // two cells, one row: nearly every print wraps and clears
        drain();
        program_frame(13'd16, 13'd16, 4'd8, 5'd16, 32'hFFFF_FFFF);
        random_items(ITEMS_PER_SEG);

        // phase two: the other way round
        drain();
        send_idle_pct = 75;
        recv_idle_pct = 34;
        program_frame(13'd4096, 13'd4096, 4'd1, 5'd1, $urandom);
        random_items(ITEMS_PER_SEG);

        // zero and overrange registers: clamped glyph, single row
        drain();
        program_frame(13'h1FFF, 13'd0, 4'd0, 5'd0, $urandom);
        random_items(ITEMS_PER_SEG);

        // phase three: no idling
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_frame(13'd100, 13'd50, 4'd15, 5'd31, $urandom);
        random_items(ITEMS_PER_SEG);

        drain();
        program_frame(13'($urandom_range(4096, 16)), 13'($urandom_range(4096, 16)),
                      4'($urandom_range(8, 1)), 5'($urandom_range(16, 1)), $urandom);
        random_items(ITEMS_PER_SEG);

        drain();
        if (mismatch_count == 0)
        begin
            $display("text_console_glyph_renderer_unit regression: pass");
        end
        else
        begin
            $display("text_console_glyph_renderer_unit regression: fail");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("text_console_glyph_renderer_unit regression: fail");
        $finish;
    end

endmodule
